/* design/srtf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

  localparam int MAX_TASKS_DEF = 16;

  // Function codes of an input beat.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [31:0] tick_time;
    logic        idle;
    logic [7:0]  run_id;
    logic [15:0] left;
    logic        finished;
    logic [31:0] response;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
  } out_item_t;

  // One entry of the task table.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic        started;
    logic [31:0] response;
  } slot_t;

endpackage

`default_nettype wire

/* design/srtf_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface srtf_in_if
  import srtf_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srtf_out_if
  import srtf_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/srtf_cpu_scheduler_top.sv */
// Shortest-remaining-time-first scheduler. A load beat (func = 0) stores a task in the next
// free slot of a MAX_TASKS-entry table and gives no result; loads into a full table are
// dropped. A tick beat (func = 1) picks a task: the table lives in a synchronous RAM with
// one registered read port, so picking the task scans the loaded slots one per cycle, then
// the FIN state, once the output is free, updates the chosen slot and registers the result
// beat. One item is in work at a time; a new beat is taken while a previous result still
// waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module srtf_cpu_scheduler_top
  import srtf_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srtf_in_if.sink    in_ch,
  srtf_out_if.source out_ch
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  slot_t mem [MAX_TASKS];

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] task_count_r, task_count_nxt;
  logic [CNT_W-1:0] done_count_r, done_count_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             found_r, found_nxt;
  slot_t            best_r, best_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  slot_t            rd_data_r;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;

  logic             in_acc;
  logic             scan_more;
  logic             fin_go;
  logic             eligible;
  logic             better;
  logic [15:0]      new_rem;
  logic [31:0]      resp;
  logic [31:0]      turn;
  logic [31:0]      wait_time;
  logic             done_inc;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;

  assign scan_more = (scan_cnt_r < task_count_r);
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign rd_addr   = scan_cnt_r[IDX_W-1:0];

  // Candidate from the slot read last cycle.
  assign eligible = rd_vld_r && (rd_data_r.remaining != 16'd0) &&
                    ({16'd0, rd_data_r.arrival} <= now_r);
  assign better   = !found_r || (rd_data_r.remaining < best_r.remaining) ||
                    ((rd_data_r.remaining == best_r.remaining) &&
                     (rd_data_r.arrival < best_r.arrival));

  assign new_rem   = best_r.remaining - 16'd1;
  assign resp      = best_r.started ? best_r.response : (now_r - {16'd0, best_r.arrival});
  assign turn      = now_r + 32'd1 - {16'd0, best_r.arrival};
  assign wait_time = turn - {16'd0, best_r.burst};
  assign done_inc  = found_r && (new_rem == 16'd0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.data.func == FUNC_TICK)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_more) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    task_count_nxt = task_count_r;
    done_count_nxt = done_count_r;
    now_nxt        = now_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = best_idx_r;
    wr_data        = best_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.func == FUNC_LOAD) begin
            if (task_count_r < CNT_W'(MAX_TASKS)) begin
              wr_en             = 1'b1;
              wr_addr           = task_count_r[IDX_W-1:0];
              wr_data.id        = in_ch.data.task_id;
              wr_data.arrival   = in_ch.data.arrival;
              wr_data.burst     = in_ch.data.burst;
              wr_data.remaining = in_ch.data.burst;
              wr_data.started   = 1'b0;
              wr_data.response  = 32'd0;
              task_count_nxt    = task_count_r + CNT_W'(1);
              // A zero-burst task is complete from the start.
              if (in_ch.data.burst == 16'd0) done_count_nxt = done_count_r + CNT_W'(1);
            end
          end else begin
            scan_cnt_nxt = '0;
            found_nxt    = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
        // Strict compare keeps the lower slot on a full tie.
        if (eligible && better) begin
          best_nxt     = rd_data_r;
          best_idx_nxt = rd_idx_r;
          found_nxt    = 1'b1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          wr_en             = found_r;
          wr_data.remaining = new_rem;
          wr_data.started   = 1'b1;
          wr_data.response  = resp;
          done_count_nxt    = done_count_r + CNT_W'(done_inc);
          now_nxt           = now_r + 32'd1;
          out_valid_nxt     = 1'b1;
          out_data_nxt.tick_time  = now_r;
          out_data_nxt.idle       = !found_r;
          out_data_nxt.run_id     = found_r ? best_r.id : 8'd0;
          out_data_nxt.left       = found_r ? new_rem : 16'd0;
          out_data_nxt.finished   = done_inc;
          out_data_nxt.response   = done_inc ? resp : 32'd0;
          out_data_nxt.turnaround = done_inc ? turn : 32'd0;
          out_data_nxt.waiting    = done_inc ? wait_time : 32'd0;
          out_data_nxt.all_done   = (done_count_nxt == task_count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_count_r <= '0;
      done_count_r <= '0;
      now_r        <= 32'd0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      done_count_r <= done_count_nxt;
      now_r        <= now_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r <= scan_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Task table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

`ifndef ASSERT_OFF
  a_done_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_count_r <= task_count_r)
    else $error("more tasks completed than loaded");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("table read returned outside the scan");

  a_best_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && (state_r == ST_FIN)) |-> (CNT_W'(best_idx_r) < task_count_r))
    else $error("chosen slot lies beyond the loaded tasks");

  a_now_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (now_r != $past(now_r))) |->
      ($past(state_r) == ST_FIN) && out_valid_r)
    else $error("time advanced without a result beat");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import srtf_pkg::*;

  localparam int TABLE_SIZE   = MAX_TASKS_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 3 * (TABLE_SIZE + 3);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  srtf_in_if  in_if ();
  srtf_out_if out_if ();

  srtf_cpu_scheduler_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #10 clk = ~clk;

  // Shadow copy of the task table and the scheduler clock.
  slot_t       sh_slot [TABLE_SIZE];
  int          sh_loaded = 0;
  int          sh_done   = 0;
  logic [31:0] sh_now    = '0;

  out_item_t pending_ticks [$];

  int errors       = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;

  function automatic void store_task(input in_item_t it);
    if (sh_loaded < TABLE_SIZE) begin
      sh_slot[sh_loaded].id        = it.task_id;
      sh_slot[sh_loaded].arrival   = it.arrival;
      sh_slot[sh_loaded].burst     = it.burst;
      sh_slot[sh_loaded].remaining = it.burst;
      sh_slot[sh_loaded].started   = 1'b0;
      sh_slot[sh_loaded].response  = '0;
      // A task with no work is complete the moment it is stored.
      if (it.burst == 16'd0) sh_done++;
      sh_loaded++;
    end
  endfunction

  function automatic out_item_t run_tick();
    out_item_t   r;
    bit          found;
    int          best;
    logic [31:0] turn;
    r           = '0;
    r.tick_time = sh_now;
    found       = 1'b0;
    best        = 0;
    for (int i = 0; i < sh_loaded; i++) begin
      if (sh_slot[i].remaining != 16'd0 && {16'd0, sh_slot[i].arrival} <= sh_now) begin
        // Strict compares keep the lower slot on a full tie.
        if (!found || sh_slot[i].remaining < sh_slot[best].remaining ||
            (sh_slot[i].remaining == sh_slot[best].remaining &&
             sh_slot[i].arrival < sh_slot[best].arrival)) begin
          best  = i;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      r.idle = 1'b1;
    end else begin
      if (!sh_slot[best].started) begin
        sh_slot[best].started  = 1'b1;
        sh_slot[best].response = sh_now - {16'd0, sh_slot[best].arrival};
      end
      sh_slot[best].remaining = sh_slot[best].remaining - 16'd1;
      r.run_id = sh_slot[best].id;
      r.left   = sh_slot[best].remaining;
      if (sh_slot[best].remaining == 16'd0) begin
        turn         = sh_now + 32'd1 - {16'd0, sh_slot[best].arrival};
        sh_done++;
        r.finished   = 1'b1;
        r.response   = sh_slot[best].response;
        r.turnaround = turn;
        r.waiting    = turn - {16'd0, sh_slot[best].burst};
      end
    end
    r.all_done = (sh_done == sh_loaded);
    sh_now++;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_ticks.size() == 0) begin
      $error("result beat with no tick waiting, tick_time %0d", got.tick_time);
      errors++;
    end else begin
      want = pending_ticks.pop_front();
      check_field("tick_time", want.tick_time, got.tick_time);
      check_field("idle", 32'(want.idle), 32'(got.idle));
      check_field("run_id", 32'(want.run_id), 32'(got.run_id));
      check_field("left", 32'(want.left), 32'(got.left));
      check_field("finished", 32'(want.finished), 32'(got.finished));
      check_field("response", want.response, got.response);
      check_field("turnaround", want.turnaround, got.turnaround);
      check_field("waiting", want.waiting, got.waiting);
      check_field("all_done", 32'(want.all_done), 32'(got.all_done));
    end
  endtask

  // Valid stays high across back-to-back beats; it only drops for an idle gap.
  task automatic send_item(input in_item_t it);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (it.func == FUNC_LOAD) store_task(it);
    else pending_ticks.push_back(run_tick());
    gap = 0;
    while (!no_idle && $urandom_range(0, 99) < 33) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [7:0] id, input logic [15:0] arrival,
                           input logic [15:0] burst);
    in_item_t it;
    it.func    = FUNC_LOAD;
    it.task_id = id;
    it.arrival = arrival;
    it.burst   = burst;
    send_item(it);
  endtask

  // The load fields of a tick beat are don't-care, so they carry noise.
  task automatic send_tick();
    in_item_t it;
    it.func    = FUNC_TICK;
    it.task_id = 8'($urandom);
    it.arrival = 16'($urandom);
    it.burst   = 16'($urandom);
    send_item(it);
  endtask

  task automatic send_random_load();
    logic [15:0] arrival;
    logic [15:0] burst;
    case ($urandom_range(0, 3))
      0:       arrival = 16'($urandom);
      1:       arrival = sh_now[15:0] - 16'($urandom_range(0, 50));
      default: arrival = sh_now[15:0] + 16'($urandom_range(0, 200));
    endcase
    if ($urandom_range(0, 9) == 0) burst = 16'($urandom_range(0, 3));
    else burst = 16'($urandom_range(1, 120));
    send_load(8'($urandom_range(0, 255)), arrival, burst);
  endtask

  task automatic test_empty_table();
    repeat (2) send_tick();
  endtask

  task automatic test_tie_breaks();
    // The last two tasks share remaining time and arrival; the first arrives later.
    send_load(8'd0, sh_now[15:0], 16'd3);
    send_load(8'd255, sh_now[15:0] - 16'd1, 16'd3);
    send_load(8'd7, sh_now[15:0] - 16'd1, 16'd3);
    repeat (4) send_tick();
  endtask

  task automatic test_zero_burst();
    send_load(8'd9, 16'd0, 16'd0);
    repeat (2) send_tick();
  endtask

  task automatic test_preemption();
    send_load(8'd100, sh_now[15:0] + 16'd1, 16'd1);
    repeat (3) send_tick();
  endtask

  task automatic test_random_fill();
    while (sh_loaded < TABLE_SIZE - 1) begin
      if ($urandom_range(0, 5) == 0) send_random_load();
      else send_tick();
    end
  endtask

  task automatic test_table_full();
    // The last slot gets a task that never arrives; later loads are dropped.
    send_load(8'h5A, 16'hFFFF, 16'hFFFF);
    repeat (3) send_random_load();
  endtask

  task automatic test_random_ticks();
    hold_request = 1'b1;
    for (int n = 0; n < 1000; n++) begin
      no_idle = (n >= 400 && n < 600);
      if ($urandom_range(0, 19) == 0) send_random_load();
      else send_tick();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result(out_if.data);
      if (hold_request && hold_left == 0) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_tie_breaks();
    test_zero_burst();
    test_preemption();
    test_random_fill();
    test_table_full();
    test_random_ticks();

    in_if.valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_ticks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
